@@ src/olads_pkg.sv @@
// Package for the ordered list block: operation and status codes,
// sequencer state type and field widths. No dependencies.
package olads_pkg;

	// Field widths of the request and response words.
	localparam int MODE_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 3;

	// Default list depth and the most entries a read out returns.
	localparam int LIST_DEPTH_DEF = 16;
	localparam int RESULT_CAP     = 16;

	// Operation codes carried in the mode field.
	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND = 2'd0,
		MODE_READ   = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_SEARCH = 2'd3
	} mode_t;

	// Status codes returned with each response word.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FULL      = 3'd2,
		ST_BAD_POS   = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_RO_ADDR,
		S_RO_DATA,
		S_DEL_ADDR,
		S_DEL_DATA,
		S_SR_ADDR,
		S_SR_DATA,
		S_EMIT
	} state_t;

endpackage

@@ src/olads_if.sv @@
// Valid/ready channel interfaces for the ordered list block.
// Depends on olads_pkg for field widths and types.
interface olads_req_if;
	logic                                  valid;
	logic                                  ready;
	olads_pkg::mode_t                      mode;
	logic signed [olads_pkg::VALUE_W-1:0]  value;
	logic        [olads_pkg::POS_W-1:0]    position;

	modport source (output valid, output mode, output value, output position, input ready);
	modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface olads_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [olads_pkg::VALUE_W-1:0]  item_value;
	logic        [olads_pkg::POS_W-1:0]    item_position;
	olads_pkg::status_t                    status;
	logic                                  last;

	modport source (output valid, output item_value, output item_position, output status,
		output last, input ready);
	modport sink   (input valid, input item_value, input item_position, input status,
		input last, output ready);
endinterface

@@ src/ordered_list_append_delete_search.sv @@
// Ordered list of signed 32-bit entries: append, read out, delete, search.
// Append and error cases go from dispatch to the emit state, which registers their word.
// Read out takes an address and a data state per entry, delete the same per entry
// shifted down and search the same per entry compared, set by the store's registered read port.
// One request at a time; the next is taken once the last word is registered.
// Reset clears the entry count and the handshake state; the store is not cleared.
module ordered_list_append_delete_search #(
	parameter int LIST_DEPTH = olads_pkg::LIST_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	olads_req_if.sink   req,
	olads_rsp_if.source rsp
);
	import olads_pkg::*;

	localparam int AW = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);

	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic signed [VALUE_W-1:0] mem_wdata;
	logic [AW-1:0]             mem_raddr;
	logic signed [VALUE_W-1:0] mem_rdata;

	// Sequencer and compare unit.
	olads_seq #(
		.DEPTH (LIST_DEPTH),
		.AW    (AW),
		.CW    (CW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Entry store.
	olads_store #(
		.DEPTH (LIST_DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

@@ src/olads_store.sv @@
// Entry store of the ordered list: one write port and one read port
// with registered read data. Depends on olads_pkg for the entry width.
module olads_store #(
	parameter int DEPTH = olads_pkg::LIST_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [AW-1:0]                        waddr,
	input  logic signed [olads_pkg::VALUE_W-1:0] wdata,
	input  logic [AW-1:0]                        raddr,
	output logic signed [olads_pkg::VALUE_W-1:0] rdata
);
	import olads_pkg::*;

	logic signed [VALUE_W-1:0] mem_q [DEPTH];
	logic signed [VALUE_W-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data registered.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/olads_seq.sv @@
// Sequencer of the ordered list: walks the entry store one address at a
// time through a single compare unit and owns the response register.
// Depends on olads_pkg and the olads_req_if / olads_rsp_if interfaces.
module olads_seq #(
	parameter int DEPTH = olads_pkg::LIST_DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	olads_req_if.sink                            req,
	olads_rsp_if.source                          rsp,
	output logic                                 mem_we,
	output logic [AW-1:0]                        mem_waddr,
	output logic signed [olads_pkg::VALUE_W-1:0] mem_wdata,
	output logic [AW-1:0]                        mem_raddr,
	input  logic signed [olads_pkg::VALUE_W-1:0] mem_rdata
);
	import olads_pkg::*;

	state_t                    state_q, state_d;
	mode_t                     op_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [POS_W-1:0]          pos_q;
	logic [AW-1:0]             idx_q, idx_d;
	logic                      idx_load;
	logic [CW-1:0]             count_q;
	logic                      count_inc, count_dec;
	logic [POS_W-1:0]          res_pos_q, res_pos_d;
	status_t                   res_status_q, res_status_d;
	logic                      res_load;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q, out_value_d;
	logic [POS_W-1:0]          out_pos_q, out_pos_d;
	status_t                   out_status_q, out_status_d;
	logic                      out_last_q, out_last_d;
	logic                      out_load;

	logic out_free, list_full, list_empty, bad_pos, del_tail;
	logic idx_end, ro_last, del_done, hit;

	// Conditions on the count, the walk index and the compare unit.
	assign out_free   = !out_valid_q || rsp.ready;
	assign list_full  = (count_q == CW'(DEPTH));
	assign list_empty = (count_q == '0);
	assign bad_pos    = (32'(pos_q) >= 32'(count_q));
	assign del_tail   = (32'(pos_q) + 32'd1 >= 32'(count_q));
	assign idx_end    = (32'(idx_q) + 32'd1 == 32'(count_q));
	assign ro_last    = idx_end || (32'(idx_q) == 32'(RESULT_CAP - 1));
	assign del_done   = (32'(idx_q) + 32'd2 >= 32'(count_q));
	assign hit        = (mem_rdata == value_q);

	assign req.ready  = (state_q == S_IDLE);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				unique case (op_q)
					MODE_APPEND: state_d = S_EMIT;
					MODE_READ:   state_d = list_empty ? S_EMIT : S_RO_ADDR;
					MODE_DELETE: state_d = (list_empty || bad_pos || del_tail) ?
						S_EMIT : S_DEL_ADDR;
					MODE_SEARCH: state_d = list_empty ? S_EMIT : S_SR_ADDR;
					default:     state_d = S_EMIT;
				endcase
			end
			S_RO_ADDR: state_d = S_RO_DATA;
			S_RO_DATA: begin
				if (out_free) state_d = ro_last ? S_IDLE : S_RO_ADDR;
			end
			S_DEL_ADDR: state_d = S_DEL_DATA;
			S_DEL_DATA: state_d = del_done ? S_EMIT : S_DEL_ADDR;
			S_SR_ADDR:  state_d = S_SR_DATA;
			S_SR_DATA: begin
				if (hit || idx_end) state_d = S_EMIT;
				else                state_d = S_SR_ADDR;
			end
			S_EMIT: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Store read address: a delete reads one entry ahead of the one it rewrites.
	assign mem_raddr = (state_q == S_DEL_ADDR) ? idx_q + AW'(1) : idx_q;

	// Per-state actions on the store, counters and response register.
	always_comb begin
		mem_we       = 1'b0;
		mem_waddr    = idx_q;
		mem_wdata    = mem_rdata;
		idx_load     = 1'b0;
		idx_d        = idx_q + AW'(1);
		count_inc    = 1'b0;
		count_dec    = 1'b0;
		res_load     = 1'b0;
		res_pos_d    = '0;
		res_status_d = ST_OK;
		out_load     = 1'b0;
		out_value_d  = '0;
		out_pos_d    = res_pos_q;
		out_status_d = res_status_q;
		out_last_d   = 1'b1;
		unique case (state_q)
			S_DISPATCH: begin
				res_load = 1'b1;
				idx_load = 1'b1;
				idx_d    = '0;
				unique case (op_q)
					MODE_APPEND: begin
						if (list_full) begin
							res_status_d = ST_FULL;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = count_q[AW-1:0];
							mem_wdata = value_q;
							count_inc = 1'b1;
							res_pos_d = POS_W'(count_q);
						end
					end
					MODE_READ: begin
						if (list_empty) res_status_d = ST_EMPTY;
					end
					MODE_DELETE: begin
						if (list_empty) begin
							res_status_d = ST_EMPTY;
						end else if (bad_pos) begin
							res_status_d = ST_BAD_POS;
						end else begin
							res_pos_d = pos_q;
							idx_d     = AW'(pos_q);
							count_dec = del_tail;
						end
					end
					MODE_SEARCH: begin
						if (list_empty) res_status_d = ST_NOT_FOUND;
					end
					default: res_status_d = ST_OK;
				endcase
			end
			S_RO_DATA: begin
				if (out_free) begin
					out_load     = 1'b1;
					out_value_d  = mem_rdata;
					out_pos_d    = POS_W'(idx_q);
					out_status_d = ST_OK;
					out_last_d   = ro_last;
					idx_load     = !ro_last;
				end
			end
			S_DEL_DATA: begin
				// Move the next entry down into the gap.
				mem_we    = 1'b1;
				idx_load  = 1'b1;
				count_dec = del_done;
			end
			S_SR_DATA: begin
				if (hit) begin
					res_load  = 1'b1;
					res_pos_d = POS_W'(idx_q);
				end else if (idx_end) begin
					res_load     = 1'b1;
					res_status_d = ST_NOT_FOUND;
				end else begin
					idx_load = 1'b1;
				end
			end
			S_EMIT: begin
				out_load = out_free;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (count_inc)      count_q <= count_q + CW'(1);
			else if (count_dec) count_q <= count_q - CW'(1);
			if (out_load)       out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers: latched request, walk index, pending result, response word.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q    <= req.mode;
			value_q <= req.value;
			pos_q   <= req.position;
		end
		if (idx_load) idx_q <= idx_d;
		if (res_load) begin
			res_pos_q    <= res_pos_d;
			res_status_q <= res_status_d;
		end
		if (out_load) begin
			out_value_q  <= out_value_d;
			out_pos_q    <= out_pos_d;
			out_status_q <= out_status_d;
			out_last_q   <= out_last_d;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.item_value    = out_value_q;
	assign rsp.item_position = out_pos_q;
	assign rsp.status        = out_status_q;
	assign rsp.last          = out_last_q;

endmodule
